// ===== sv/ntid_pkg.sv =====
// Shared types, codes and key normalization for the name-to-id lookup table.
`default_nettype none

package ntid_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int NAME_BYTES_DEF  = 8;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_LOOKUP   = 2'd1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_INVALID   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] name_key;
        logic [7:0]  caller_id;
    } req_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] found_id;
    } rsp_t;

    function automatic logic [63:0] normalize_key(input logic [63:0] key, input int name_bytes);
        logic [63:0] out;
        logic        alive;
        out   = '0;
        alive = 1'b1;
        for (int b = 0; b < 8; b++)
        begin
            if (b >= name_bytes || key[8*b +: 8] == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                out[8*b +: 8] = key[8*b +: 8];
            end
        end
        return out;
    endfunction

endpackage

`default_nettype wire

// ===== sv/name_to_id_register_lookup.sv =====
// Name table: registers name keys with task ids and looks them up by linear search.
//
//   channel   signals                            handshake
//   request   req (operation, key, caller id)    accepted when start is high and busy is low
//   result    rsp (status, found_id)             valid for one cycle while done is high
//
// A request reads the stored entries one at a time through the single read port of the
// entry memory; an invalid operation is answered from idle and leaves busy low.
// Entries are read back to back; each compare is made in the cycle after its read.
// Reset clears the fill count but not the entry memory; entries at or above it are never read.
// The result must be taken in its cycle; busy drops as done is raised.
`default_nettype none

module name_to_id_register_lookup #(
    parameter int MAX_ENTRIES = ntid_pkg::MAX_ENTRIES_DEF,
    parameter int NAME_BYTES  = ntid_pkg::NAME_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ntid_pkg::req_t req,
    output logic               done,
    output ntid_pkg::rsp_t     rsp
);
    import ntid_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    typedef struct packed {
        logic [63:0] key;
        logic [7:0]  id;
    } entry_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } state_t;

    entry_t mem [MAX_ENTRIES];

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] issue_idx_reg;
    logic             rd_valid_reg;
    logic             rd_last_reg;
    entry_t           rd_data_reg;
    logic [1:0]       op_reg;
    logic [63:0]      key_reg;
    logic [7:0]       id_reg;
    logic             done_reg;
    rsp_t             rsp_reg;

    logic             accept;
    logic             bad_op;
    logic             issue;
    logic             hit;
    logic             miss;
    logic             full;
    logic             wr_en;
    entry_t           wr_data;

    always_comb
    begin
        accept  = start && (state_reg == S_IDLE);
        bad_op  = (req.operation != OP_REGISTER) && (req.operation != OP_LOOKUP);
        issue   = (state_reg == S_SCAN) && (issue_idx_reg < count_reg);
        hit     = (state_reg == S_SCAN) && rd_valid_reg && (rd_data_reg.key == key_reg);
        miss    = (state_reg == S_SCAN) && !hit
                  && ((count_reg == '0) || (rd_valid_reg && rd_last_reg));
        full    = (count_reg == CNT_W'(MAX_ENTRIES));
        wr_en   = miss && (op_reg == OP_REGISTER) && !full;
        wr_data = '{key: key_reg, id: id_reg};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        if (issue)
        begin
            rd_data_reg <= mem[issue_idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            op_reg        <= OP_REGISTER;
            key_reg       <= '0;
            id_reg        <= '0;
            done_reg      <= 1'b0;
            rsp_reg       <= '{status: ST_OK, found_id: 8'd0};
        end
        else
        begin
            done_reg <= (accept && bad_op) || hit || miss;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg        <= req.operation;
                        key_reg       <= normalize_key(req.name_key, NAME_BYTES);
                        id_reg        <= req.caller_id;
                        issue_idx_reg <= '0;
                        rd_valid_reg  <= 1'b0;
                        if (!bad_op)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            rsp_reg  <= '{status: ST_INVALID, found_id: 8'd0};
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_valid_reg <= issue && !hit;
                    rd_last_reg  <= (issue_idx_reg == count_reg - CNT_W'(1));
                    if (issue)
                    begin
                        issue_idx_reg <= issue_idx_reg + CNT_W'(1);
                    end
                    if (hit)
                    begin
                        state_reg    <= S_IDLE;
                        if (op_reg == OP_REGISTER)
                        begin
                            rsp_reg <= '{status: ST_DUPLICATE, found_id: 8'd0};
                        end
                        else
                        begin
                            rsp_reg <= '{status: ST_OK, found_id: rd_data_reg.id};
                        end
                    end
                    else if (miss)
                    begin
                        state_reg    <= S_IDLE;
                        if (op_reg == OP_REGISTER)
                        begin
                            if (full)
                            begin
                                rsp_reg <= '{status: ST_FULL, found_id: 8'd0};
                            end
                            else
                            begin
                                count_reg <= count_reg + CNT_W'(1);
                                rsp_reg   <= '{status: ST_OK, found_id: 8'd0};
                            end
                        end
                        else
                        begin
                            rsp_reg <= '{status: ST_NOT_FOUND, found_id: 8'd0};
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire
